[hdl/utf8_stream_decoder_defines.svh]
// Assertion macros used by the checker file.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define U8SD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define U8SD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/u8sd_pkg.sv]
package u8sd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 31;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned IN_LIM_W = 15;
  localparam int unsigned REM_W    = 3;
  localparam int unsigned OUT_W    = 48;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [IN_LIM_W-1:0] IN_LIMIT_RESET  = 15'h7FFF;
  localparam logic [COUNT_W-1:0]  OUT_LIMIT_RESET = 16'hFFFF;
  localparam logic [COUNT_W-1:0]  POS_MAX         = 16'hFFFF;

  // Leads whose shortest continuation is overlong
  localparam logic [BYTE_W-1:0] LEAD_E0 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_F0 = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_F8 = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_FC = 8'hFC;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_BYTE_LIMIT  = 1'b0,
    CFG_OUTPUT_CHAR_LIMIT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [REM_W-1:0]   remaining;
    logic [BYTE_W-1:0]  lead;
    logic               second_pending;
    logic [CP_W-1:0]    partial;
    logic [COUNT_W-1:0] pos;
    logic [COUNT_W-1:0] chars;
    logic               finished;
  } dec_state_t;

  typedef struct packed {
    logic               present;
    logic [CP_W-1:0]    code_point;
    logic               char_valid;
    logic               done;
    logic [COUNT_W-1:0] char_count;
  } dec_result_t;

endpackage

[hdl/utf8_stream_decoder.sv]
// UTF-8 byte stream to code point decoder.
// Bytes enter on the s_ stream, one word per byte, tlast on the final byte of
// a string. Results leave on the m_ stream: tdata carries the code point and
// the running character count, tuser flags a completed character, tlast
// marks the result for the final byte. Bytes that complete no character and
// are not last produce no word.
// Limits are written on the cfg channel (index 0 input byte limit, index 1
// output character limit); the user must write them only between strings,
// which the block does not enforce. cfg_ready is always high. Throughput is
// one byte per cycle while m_tready is not held low. A byte taken sits in the
// input register, is decoded and its result is held in the result register.
// When the receiver holds m_tready low the result word holds and the input
// register fills; s_tready then drops until the result is taken.
// Synchronous reset empties both registers, clears the decoder state and
// restores both limits to their maximum values.
module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
  input  logic                 s_tlast,   // in_last
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // [30:0] code_point, [46:31] char_count, [47] zero
  output logic                 m_tuser,   // char_valid
  output logic                 m_tlast,   // done_res
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data
);

  logic [IN_LIM_W-1:0] input_byte_limit;
  logic [COUNT_W-1:0]  output_char_limit;

  logic                in_valid;
  logic [BYTE_W-1:0]   in_byte;
  logic                in_last;

  dec_state_t          state;
  dec_state_t          state_next;
  dec_result_t         step_res;

  logic [CP_W-1:0]     out_code;
  logic [COUNT_W-1:0]  out_count;
  logic                out_char;
  logic                out_done;

  logic                out_free;
  logic                fire;

  assign out_free  = !m_tvalid || m_tready;
  assign fire      = in_valid && out_free;
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_byte_limit  <= IN_LIMIT_RESET;
      output_char_limit <= OUT_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INPUT_BYTE_LIMIT:  input_byte_limit  <= cfg_data[IN_LIM_W-1:0];
        CFG_OUTPUT_CHAR_LIMIT: output_char_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  u8sd_step u_step (
    .state_cur         (state),
    .byte_in           (in_byte),
    .last_in           (in_last),
    .input_byte_limit  (input_byte_limit),
    .output_char_limit (output_char_limit),
    .state_next        (state_next),
    .result            (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= fire && step_res.present;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step_res.present) begin
      out_code  <= step_res.code_point;
      out_count <= step_res.char_count;
      out_char  <= step_res.char_valid;
      out_done  <= step_res.done;
    end
  end

  assign m_tdata = {1'b0, out_count, out_code};
  assign m_tuser = out_char;
  assign m_tlast = out_done;

endmodule

[hdl/u8sd_step.sv]
module u8sd_step
  import u8sd_pkg::*;
(
  input  dec_state_t           state_cur,
  input  logic [BYTE_W-1:0]    byte_in,
  input  logic                 last_in,
  input  logic [IN_LIM_W-1:0]  input_byte_limit,
  input  logic [COUNT_W-1:0]   output_char_limit,
  output dec_state_t           state_next,
  output dec_result_t          result
);

  logic            is_cont;
  logic            overlong;

  assign is_cont = (byte_in[7:6] == 2'b10);

  always_comb begin
    overlong = 1'b0;
    if (state_cur.second_pending) begin
      case (state_cur.lead)
        LEAD_E0: overlong = (byte_in[7:5] == 3'b100);
        LEAD_F0: overlong = (byte_in[7:4] == 4'b1000);
        LEAD_F8: overlong = (byte_in[7:3] == 5'b10000);
        LEAD_FC: overlong = (byte_in[7:2] == 6'b100000);
        default: overlong = 1'b0;
      endcase
    end
  end

  always_comb begin
    dec_state_t      s;
    logic            have;
    logic [CP_W-1:0] cp;
    logic            do_start;
    s        = state_cur;
    have     = 1'b0;
    cp       = '0;
    do_start = 1'b0;

    if (s.finished || s.remaining == '0) begin
      do_start = 1'b1;
    end else if (!is_cont || overlong) begin
      // drop the open sequence, then treat the byte as a lead
      s.remaining      = '0;
      s.lead           = '0;
      s.second_pending = 1'b0;
      s.partial        = '0;
      do_start         = 1'b1;
    end else begin
      s.partial        = {s.partial[CP_W-7:0], byte_in[5:0]};
      s.second_pending = 1'b0;
      s.remaining      = s.remaining - REM_W'(1);
      if (s.remaining == '0) begin
        have             = 1'b1;
        cp               = s.partial;
        s.lead           = '0;
        s.partial        = '0;
      end
    end

    if (do_start && !s.finished) begin
      if (byte_in == '0 || s.pos >= {1'b0, input_byte_limit} || s.chars >= output_char_limit) begin
        s.finished = 1'b1;
      end else if (!byte_in[7]) begin
        have = 1'b1;
        cp   = CP_W'(byte_in);
      end else if (byte_in[7:5] == 3'b110) begin
        // C0 and C1 are always overlong
        if (byte_in[7:1] != 7'b1100000) begin
          s.remaining      = REM_W'(1);
          s.lead           = byte_in;
          s.second_pending = 1'b1;
          s.partial        = CP_W'(byte_in[4:0]);
        end
      end else if (byte_in[7:4] == 4'b1110) begin
        s.remaining      = REM_W'(2);
        s.lead           = byte_in;
        s.second_pending = 1'b1;
        s.partial        = CP_W'(byte_in[3:0]);
      end else if (byte_in[7:3] == 5'b11110) begin
        s.remaining      = REM_W'(3);
        s.lead           = byte_in;
        s.second_pending = 1'b1;
        s.partial        = CP_W'(byte_in[2:0]);
      end else if (byte_in[7:2] == 6'b111110) begin
        s.remaining      = REM_W'(4);
        s.lead           = byte_in;
        s.second_pending = 1'b1;
        s.partial        = CP_W'(byte_in[1:0]);
      end else if (byte_in[7:1] == 7'b1111110) begin
        s.remaining      = REM_W'(5);
        s.lead           = byte_in;
        s.second_pending = 1'b1;
        s.partial        = CP_W'(byte_in[0]);
      end
    end

    if (have) begin
      s.chars = s.chars + COUNT_W'(1);
    end
    if (s.pos != POS_MAX) begin
      s.pos = s.pos + COUNT_W'(1);
    end

    result.present    = have || last_in;
    result.code_point = cp;
    result.char_valid = have;
    result.done       = last_in;
    result.char_count = s.chars;

    if (last_in) begin
      s = '0;
    end
    state_next = s;
  end

endmodule

[hdl/u8sd_checker.sv]
`include "utf8_stream_decoder_defines.svh"

module u8sd_checker
  import u8sd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_W-1:0]     m_tdata,
  input logic                 m_tuser,
  input logic                 m_tlast
);

  logic                 out_stall;
  logic [OUT_W+1:0]     out_word;
  logic [CP_W-1:0]      code_seen;
  logic [COUNT_W-1:0]   count_seen;
  logic                 pad_seen;

  assign out_stall  = m_tvalid && !m_tready;
  assign out_word   = {m_tlast, m_tuser, m_tdata};
  assign code_seen  = m_tdata[CP_W-1:0];
  assign count_seen = m_tdata[CP_W+COUNT_W-1:CP_W];
  assign pad_seen   = m_tdata[OUT_W-1];

  `U8SD_ASSERT_NXT(a_out_hold, clk, rst, out_stall, m_tvalid, "result word dropped while stalled")

  `U8SD_ASSERT_NXT(a_out_stable, clk, rst, out_stall, $stable(out_word), "word changed while stalled")

  `U8SD_ASSERT_IMP(a_word_reason, clk, rst, m_tvalid, m_tuser || m_tlast, "empty result word")

  `U8SD_ASSERT_IMP(a_no_char_zero, clk, rst, m_tvalid && !m_tuser, code_seen == '0, "stray code point")

  `U8SD_ASSERT_IMP(a_count_nonzero, clk, rst, m_tvalid && m_tuser, count_seen != '0 && !pad_seen, "bad count or pad")

endmodule

bind utf8_stream_decoder u8sd_checker u_chk (.*);
